FILE: sv/mexp_pkg.sv
package mexp_pkg;

  localparam int unsigned WidthDefault = 32;
  localparam int unsigned WidthMin     = 8;
  localparam int unsigned WidthMax     = 64;

endpackage

FILE: sv/mexp_if.sv
interface mexp_in_if #(
  parameter int unsigned WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] base;
  logic [WIDTH-1:0] exponent;
  logic [WIDTH-1:0] modulus;

  modport source (output valid, output base, output exponent, output modulus, input ready);
  modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mexp_out_if #(
  parameter int unsigned WIDTH = 32
);
  logic             valid;
  logic             ready;
  logic [WIDTH-1:0] power_result;
  logic             modulus_error;

  modport source (output valid, output power_result, output modulus_error, input ready);
  modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

FILE: sv/mexp_mulmod.sv
module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [WIDTH-1:0] x_i,
  input  logic [WIDTH-1:0] y_i,
  input  logic [WIDTH-1:0] m_i,
  output logic             done_o,
  output logic [WIDTH-1:0] prod_o
);

  localparam int unsigned CW = $clog2(WIDTH + 1);
  localparam int unsigned VW = WIDTH + 2;

  logic [CW-1:0]    cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] x_q, x_d;
  logic [WIDTH-1:0] y_q, y_d;
  logic [WIDTH-1:0] m_q, m_d;

  logic             busy;
  logic [VW-1:0]    v;
  logic [VW:0]      d1, d2;

  assign busy = (cnt_q != '0);

  // acc <- 2*acc + bit*x mod m; sum stays below 3m, so one of three candidates fits
  always_comb begin
    v  = {1'b0, acc_q, 1'b0} + (y_q[WIDTH-1] ? {2'b00, x_q} : {VW{1'b0}});
    d1 = {1'b0, v} - {3'b000, m_q};
    d2 = {1'b0, v} - {2'b00, m_q, 1'b0};
  end

  always_comb begin
    cnt_d  = cnt_q;
    done_d = 1'b0;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    m_d    = m_q;
    if (start_i) begin
      cnt_d = CW'(WIDTH);
      acc_d = '0;
      x_d   = x_i;
      y_d   = y_i;
      m_d   = m_i;
    end else if (busy) begin
      cnt_d  = cnt_q - CW'(1);
      done_d = (cnt_q == CW'(1));
      y_d    = {y_q[WIDTH-2:0], 1'b0};
      if (!d2[VW]) begin
        acc_d = d2[WIDTH-1:0];
      end else if (!d1[VW]) begin
        acc_d = d1[WIDTH-1:0];
      end else begin
        acc_d = v[WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

FILE: sv/modular_exponentiation.sv
// Modular exponentiation, base^exponent mod modulus, for RSA encryption and decryption.
// One word is taken at a time; ready is low while it is worked on. A zero modulus gives
// modulus_error with result 0 and a zero exponent gives 1. Otherwise the base is first
// reduced, then each of the WIDTH exponent bits, LSB first, takes a multiply when the
// bit is set and then a square, all on one shared shift-add modular multiplier that
// retires one multiplier bit per cycle. A finished result waits in an output register,
// so the next word is accepted while it is still pending.
module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  mexp_in_if.sink    req_i,
  mexp_out_if.source rsp_o
);

  localparam int unsigned BW = $clog2(WIDTH);

  localparam logic [2:0] StIdle   = 3'd0;
  localparam logic [2:0] StReduce = 3'd1;
  localparam logic [2:0] StDecide = 3'd2;
  localparam logic [2:0] StMul    = 3'd3;
  localparam logic [2:0] StSqr    = 3'd4;
  localparam logic [2:0] StFinish = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [BW-1:0]    bit_q, bit_d;
  logic [WIDTH-1:0] exp_q, exp_d;
  logic [WIDTH-1:0] mod_q, mod_d;
  logic [WIDTH-1:0] acc_q, acc_d;
  logic [WIDTH-1:0] sq_q, sq_d;
  logic             err_q, err_d;
  logic             out_valid_q, out_valid_d;
  logic [WIDTH-1:0] out_res_q, out_res_d;
  logic             out_err_q, out_err_d;

  logic             in_fire;
  logic             out_free;
  logic             mul_start;
  logic [WIDTH-1:0] mul_x, mul_y, mul_m;
  logic             mul_done;
  logic [WIDTH-1:0] mul_prod;
  logic             mod_one;

  assign req_i.ready = (state_q == StIdle);
  assign in_fire     = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign mod_one     = (req_i.modulus == WIDTH'(1));

  mexp_mulmod #(
    .WIDTH (WIDTH)
  ) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .m_i     (mul_m),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  always_comb begin
    state_d     = state_q;
    bit_d       = bit_q;
    exp_d       = exp_q;
    mod_d       = mod_q;
    acc_d       = acc_q;
    sq_d        = sq_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    out_res_d   = out_res_q;
    out_err_d   = out_err_q;
    mul_start   = 1'b0;
    mul_x       = sq_q;
    mul_y       = sq_q;
    mul_m       = mod_q;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_fire) begin
          mod_d = req_i.modulus;
          exp_d = req_i.exponent;
          bit_d = '0;
          err_d = 1'b0;
          if (req_i.modulus == '0) begin
            acc_d   = '0;
            err_d   = 1'b1;
            state_d = StFinish;
          end else if (req_i.exponent == '0) begin
            acc_d   = WIDTH'(1);
            state_d = StFinish;
          end else begin
            // base mod m as (1 mod m) * base, scanning every base bit
            acc_d     = mod_one ? '0 : WIDTH'(1);
            mul_start = 1'b1;
            mul_x     = mod_one ? '0 : WIDTH'(1);
            mul_y     = req_i.base;
            mul_m     = req_i.modulus;
            state_d   = StReduce;
          end
        end
      end
      StReduce: begin
        if (mul_done) begin
          sq_d    = mul_prod;
          state_d = StDecide;
        end
      end
      StDecide: begin
        mul_start = 1'b1;
        if (exp_q[0]) begin
          mul_x   = acc_q;
          state_d = StMul;
        end else begin
          state_d = StSqr;
        end
      end
      StMul: begin
        if (mul_done) begin
          acc_d     = mul_prod;
          mul_start = 1'b1;
          state_d   = StSqr;
        end
      end
      StSqr: begin
        if (mul_done) begin
          sq_d  = mul_prod;
          exp_d = {1'b0, exp_q[WIDTH-1:1]};
          bit_d = bit_q + BW'(1);
          if (bit_q == BW'(WIDTH - 1)) begin
            state_d = StFinish;
          end else begin
            state_d = StDecide;
          end
        end
      end
      StFinish: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_res_d   = acc_q;
          out_err_d   = err_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q     <= bit_d;
    exp_q     <= exp_d;
    mod_q     <= mod_d;
    acc_q     <= acc_d;
    sq_q      <= sq_d;
    err_q     <= err_d;
    out_res_q <= out_res_d;
    out_err_q <= out_err_d;
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.power_result  = out_res_q;
  assign rsp_o.modulus_error = out_err_q;

endmodule

FILE: sv/mexp_checker.sv
module mexp_checker
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDefault
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [WIDTH-1:0] power_result_i,
  input logic             modulus_error_i
);

  // an error word always carries a zero result
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && modulus_error_i) |-> (power_result_i == '0))
    else $error("modulus_error with nonzero power_result");

  // one word at a time: busy right after a word is taken
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("ready stayed high after an accepted word");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(power_result_i) && $stable(modulus_error_i)))
    else $error("stalled result word changed or dropped");

  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

endmodule

bind modular_exponentiation mexp_checker #(
  .WIDTH (WIDTH)
) u_mexp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .power_result_i  (rsp_o.power_result),
  .modulus_error_i (rsp_o.modulus_error)
);

FILE: test/modular_exponentiation_checker.sv
`timescale 1ns / 100ps

module modular_exponentiation_checker
  import mexp_pkg::*;
#(
  parameter int unsigned WIDTH = WidthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mexp_in_if          req_mon,
  mexp_out_if         rsp_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned accepted_o,
  output int unsigned checked_o,
  output int unsigned zero_mod_o
);

  typedef logic [WIDTH-1:0] word_t;

  typedef struct packed {
    word_t power_result;
    logic  modulus_error;
  } power_t;

  power_t      power_q[$];
  int unsigned mismatches = 0;
  int unsigned accepted   = 0;
  int unsigned checked    = 0;
  int unsigned zero_mod   = 0;

  initial begin
    errors_o   = 0;
    pending_o  = 0;
    accepted_o = 0;
    checked_o  = 0;
    zero_mod_o = 0;
  end

  // right-to-left square and multiply, products held at double width
  function automatic power_t predict_power(word_t base, word_t exponent, word_t modulus);
    logic [2*WIDTH-1:0] acc;
    logic [2*WIDTH-1:0] sq;
    logic [2*WIDTH-1:0] m;
    power_t             res;
    res.power_result  = '0;
    res.modulus_error = 1'b0;
    m = {{WIDTH{1'b0}}, modulus};
    if (modulus == '0) begin
      res.modulus_error = 1'b1;
    end else if (exponent == '0) begin
      res.power_result = word_t'(1);
    end else begin
      acc = 1 % m;
      sq  = {{WIDTH{1'b0}}, base} % m;
      for (int i = 0; i < WIDTH; i++) begin
        if (exponent[i]) begin
          acc = (acc * sq) % m;
        end
        sq = (sq * sq) % m;
      end
      res.power_result = acc[WIDTH-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, power_t want, power_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch on %s: expected result %h err %b, got result %h err %b",
               $realtime, what, want.power_result, want.modulus_error,
               got.power_result, got.modulus_error);
    end
  endtask

  always @(posedge clk_i) begin
    power_t got;
    power_t want;
    if (rst_ni) begin
      // pop before push: a result never belongs to a word taken in the same cycle
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.power_result  = rsp_mon.power_result;
        got.modulus_error = rsp_mon.modulus_error;
        checked++;
        if (got.modulus_error) begin
          zero_mod++;
        end
        if (power_q.size() == 0) begin
          want = '0;
          report_mismatch("unexpected word", want, got);
        end else begin
          want = power_q.pop_front();
          if (got.power_result !== want.power_result) begin
            report_mismatch("power_result", want, got);
          end else if (got.modulus_error !== want.modulus_error) begin
            report_mismatch("modulus_error", want, got);
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        power_q.push_back(predict_power(req_mon.base, req_mon.exponent, req_mon.modulus));
        accepted++;
      end
    end
    errors_o   <= mismatches;
    pending_o  <= power_q.size();
    accepted_o <= accepted;
    checked_o  <= checked;
    zero_mod_o <= zero_mod;
  end

endmodule

FILE: test/modular_exponentiation_tb.sv
`timescale 1ns / 100ps

module modular_exponentiation_tb;
  import mexp_pkg::*;

  localparam int unsigned W           = WidthDefault;
  localparam int unsigned NumRandom   = 256;
  localparam int unsigned HoldCycles  = 6000;
  localparam int unsigned IdleLimit   = 40000;
  localparam int unsigned QuietFirst  = 150;
  localparam int unsigned QuietLast   = 190;

  typedef logic [W-1:0] word_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  bit          hold_req = 1'b0;
  logic        quiet;
  int unsigned idle_cycles = 0;
  int unsigned errors;
  int unsigned pending;
  int unsigned accepted;
  int unsigned checked;
  int unsigned zero_mod;

  mexp_in_if  #(.WIDTH(W)) req_if ();
  mexp_out_if #(.WIDTH(W)) rsp_if ();

  modular_exponentiation #(.WIDTH(W)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  modular_exponentiation_checker #(.WIDTH(W)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_mon    (req_if),
    .rsp_mon    (rsp_if),
    .errors_o   (errors),
    .pending_o  (pending),
    .accepted_o (accepted),
    .checked_o  (checked),
    .zero_mod_o (zero_mod)
  );

  always #2 clk_i = ~clk_i;

  // no idling on either side for a window of accepted words
  assign quiet = (accepted >= QuietFirst) && (accepted < QuietLast);

  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 4);
    if (pick < 95) return $urandom_range(5, 60);
    return $urandom_range(200, 2500);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_word(word_t b, word_t e, word_t m, int unsigned gap);
    req_if.valid    <= 1'b1;
    req_if.base     <= b;
    req_if.exponent <= e;
    req_if.modulus  <= m;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_directed(word_t b, word_t e, word_t m);
    send_word(b, e, m, gap_len());
  endtask

  task automatic send_random_word();
    word_t       b;
    word_t       e;
    word_t       m;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) m = '0;
    else if (pick < 10) m = word_t'(1);
    else if (pick < 25) m = $urandom_range(1000, 2);
    else if (pick < 45) begin
      m = $urandom();
      m[W-1] = 1'b1;
    end else m = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 5) e = '0;
    else if (pick < 15) e = $urandom_range(20, 1);
    else if (pick < 20) e = word_t'(65537);
    else if (pick < 30) begin
      e = '1;
      e[$urandom_range(W-1, 0)] = 1'b0;
    end else e = $urandom();
    pick = $urandom_range(0, 99);
    if (pick < 12) b = $urandom_range('1, m);
    else if (pick < 16) b = '0;
    else if (pick < 20) b = word_t'(1);
    else b = $urandom();
    send_word(b, e, m, quiet ? 0 : gap_len());
  endtask

  initial begin
    req_if.valid    = 1'b0;
    req_if.base     = '0;
    req_if.exponent = '0;
    req_if.modulus  = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // zero modulus wins over everything
    send_directed(32'h0000_0005, 32'h0000_0003, '0);
    send_directed('1, '0, '0);
    send_directed('0, '1, '0);
    // zero exponent gives 1, modulus one included
    send_directed(32'h1234_5678, '0, word_t'(1));
    send_directed('0, '0, 32'h0000_0007);
    send_directed('1, '0, '1);
    // modulus one with nonzero exponent
    send_directed(32'hDEAD_BEEF, 32'h0000_0001, word_t'(1));
    send_directed('1, '1, word_t'(1));
    // textbook RSA round trip
    send_directed(32'd65, 32'd17, 32'd3233);
    send_directed(32'd2790, 32'd2753, 32'd3233);
    // base not below modulus, mixed with bases below it
    send_directed('1, 32'h0000_0003, 32'h0000_000D);
    send_directed(32'd3233, 32'd5, 32'd3233);
    send_directed('1, '1, '1);
    send_directed('0, 32'h0000_0005, 32'h0000_0007);
    send_directed(32'h0000_0002, '1, 32'hFFFF_FFFB);
    send_directed(32'h1234_5678, 32'hFFFF_FFFA, 32'hFFFF_FFFB);
    send_directed(32'h8765_4321, word_t'(1), 32'h8000_0000);
    send_directed(32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0002);
    send_directed(32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF);
    send_directed(32'hFFFF_FFFE, 32'h8000_0000, 32'hFFFF_FFFD);

    // let everything drain, then park the receiver while words keep coming
    req_if.valid <= 1'b0;
    wait (pending == 0);
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    repeat (4) send_word($urandom(), $urandom(), $urandom() | 32'h8000_0000, 0);

    repeat (NumRandom) send_random_word();
    req_if.valid <= 1'b0;

    wait (pending == 0);
    repeat (2500) @(posedge clk_i);
    $display("Run covered %0d words, %0d results checked, %0d with zero modulus,",
             accepted, checked, zero_mod);
    $display("one %0d-cycle output hold-off and one full drain pause; %0d mismatches.",
             HoldCycles, errors);
    if (errors == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // receiver: random ready with runs and stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left   = 0;
    rsp_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HoldCycles;
        run_left   = 0;
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        rsp_if.ready <= 1'b1;
        run_left--;
      end else begin
        run_left   = $urandom_range(16, 1);
        stall_left = quiet ? 0 : gap_len();
        if (stall_left > 0) begin
          rsp_if.ready <= 1'b0;
          stall_left--;
        end else begin
          rsp_if.ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles", IdleLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule

FILE: modular_exponentiation.f
sv/mexp_pkg.sv
sv/mexp_if.sv
sv/mexp_mulmod.sv
sv/modular_exponentiation.sv
sv/mexp_checker.sv
test/modular_exponentiation_checker.sv
test/modular_exponentiation_tb.sv
